@@ sv/integer_to_radix_symbols_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the radix symbol formatter
// Used by itrs_chk, the file that carries the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_SYMBOLS_DEFINES_SVH
`define INTEGER_TO_RADIX_SYMBOLS_DEFINES_SVH

// Clocked check that is switched off while reset is asserted.
`define ITRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define ITRS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/itrs_pkg.sv @@
// ----------------------------------------------------------------------------
// itrs_pkg
// Types, constants and helper functions of the radix symbol formatter.
// ----------------------------------------------------------------------------
package itrs_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned SymW       = 8;
  localparam int unsigned SymRegW    = 63;
  localparam int unsigned RadixW     = 5;
  localparam int unsigned MaxSymbols = 16;
  localparam int unsigned MaxDigits  = 32;
  localparam int unsigned DigitCntW  = 6;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 64;
  localparam int unsigned DivSteps   = 4;
  localparam int unsigned BitsPerDivStep = ValueW / DivSteps;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] RegSymLo = 2'd0;
  localparam logic [1:0] RegSymHi = 2'd1;
  localparam logic [1:0] RegRadix = 2'd2;

  localparam logic [SymRegW-1:0] SymLoRst = 63'h3736353433323130;
  localparam logic [SymRegW-1:0] SymHiRst = 63'h4645444342413938;
  localparam logic [RadixW-1:0]  RadixRst = 5'd10;

  localparam logic [SymW-1:0] ChNul   = 8'h00;
  localparam logic [SymW-1:0] ChTab   = 8'h09;
  localparam logic [SymW-1:0] ChLf    = 8'h0A;
  localparam logic [SymW-1:0] ChVt    = 8'h0B;
  localparam logic [SymW-1:0] ChFf    = 8'h0C;
  localparam logic [SymW-1:0] ChCr    = 8'h0D;
  localparam logic [SymW-1:0] ChSpace = 8'h20;
  localparam logic [SymW-1:0] ChPlus  = 8'h2B;
  localparam logic [SymW-1:0] ChMinus = 8'h2D;

  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
    logic emit_sign;
    logic emit_digit;
  } itrs_cmd_t;

  typedef struct packed {
    logic alpha_ok;
    logic neg;
    logic quot_zero;
    logic digits_full;
    logic last_digit;
  } itrs_stat_t;

  function automatic logic [SymW-1:0] sym_at(input logic [SymRegW-1:0] lo,
                                             input logic [SymRegW-1:0] hi,
                                             input logic [3:0]         idx);
    logic [2*SymRegW+1:0] all_syms;
    all_syms = {1'b0, hi, 1'b0, lo};
    return all_syms[{idx, 3'b000} +: SymW];
  endfunction

  function automatic logic sym_forbidden(input logic [SymW-1:0] c);
    return (c == ChNul) || (c == ChTab) || (c == ChLf) || (c == ChVt) ||
           (c == ChFf) || (c == ChCr) || (c == ChSpace) || (c == ChPlus) ||
           (c == ChMinus);
  endfunction

endpackage

@@ sv/integer_to_radix_symbols.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_symbols
// Writes a signed 32-bit number as text in a configurable base and alphabet.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  command  | start, busy, value_i                     | in/out
//  result   | result_strobe_o, symbol_o, last_o        | out
//  config   | psel, penable, pwrite, paddr, pwdata,    | in/out
//           | prdata, pready                           |
//
// Each digit takes four steps in the radix divider (eight quotient bits per
// cycle), then the symbols are emitted one per cycle, a minus sign first if
// the value is negative.
// An item with a bad alphabet or radix is dropped in the cycle it is taken.
// busy stays high through the last symbol's strobe cycle. Reset is asynchronous
// and leaves the block idle with the default alphabet "0123456789ABCDEF" and
// radix ten. Results cannot be stalled.
// ----------------------------------------------------------------------------
module integer_to_radix_symbols #(
  parameter int unsigned MAX_RADIX = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [itrs_pkg::ValueW-1:0]   value_i,
  output logic                          result_strobe_o,
  output logic [itrs_pkg::SymW-1:0]     symbol_o,
  output logic                          last_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [itrs_pkg::AddrW-1:0]    paddr,
  input  logic [itrs_pkg::DataW-1:0]    pwdata,
  output logic [itrs_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import itrs_pkg::*;

  logic [SymRegW-1:0] sym_lo_q;
  logic [SymRegW-1:0] sym_hi_q;
  logic [RadixW-1:0]  radix_q;
  logic [1:0]         reg_idx;
  logic               cfg_wr;

  itrs_cmd_t  cmd;
  itrs_stat_t stat;
  logic       ctrl_busy;
  logic       accept;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_lo_q <= SymLoRst;
      sym_hi_q <= SymHiRst;
      radix_q  <= RadixRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegSymLo: sym_lo_q <= pwdata[SymRegW-1:0];
        RegSymHi: sym_hi_q <= pwdata[SymRegW-1:0];
        RegRadix: radix_q  <= pwdata[RadixW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegSymLo: prdata = {1'b0, sym_lo_q};
      RegSymHi: prdata = {1'b0, sym_hi_q};
      RegRadix: prdata = {{(DataW-RadixW){1'b0}}, radix_q};
      default:  prdata = '0;
    endcase
  end

  // The final strobe cycle still counts as busy.
  assign busy   = ctrl_busy | result_strobe_o;
  assign accept = start && !busy;

  itrs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (ctrl_busy)
  );

  itrs_dp #(
    .MAX_RADIX (MAX_RADIX)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .value_i  (value_i),
    .sym_lo_i (sym_lo_q),
    .sym_hi_i (sym_hi_q),
    .radix_i  (radix_q),
    .strobe_o (result_strobe_o),
    .symbol_o (symbol_o),
    .last_o   (last_o)
  );

endmodule

@@ sv/itrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// itrs_ctrl
// Sequencer of the formatter: divides, then emits a minus sign if needed and the digits.
// ----------------------------------------------------------------------------
module itrs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  itrs_pkg::itrs_stat_t  stat_i,
  output itrs_pkg::itrs_cmd_t   cmd_o,
  output logic                  busy_o
);
  import itrs_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StSign = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  localparam int unsigned StepW = $clog2(DivSteps);

  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (accept_i && stat_i.alpha_ok) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == StepW'(DivSteps - 1)) begin
          // One full quotient is done; its remainder is the next digit.
          cmd_o.push = 1'b1;
          if (stat_i.quot_zero || stat_i.digits_full) begin
            state_d = stat_i.neg ? StSign : StEmit;
          end
        end
      end
      StSign: begin
        cmd_o.emit_sign = 1'b1;
        state_d         = StEmit;
      end
      StEmit: begin
        cmd_o.emit_digit = 1'b1;
        if (stat_i.last_digit) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

@@ sv/itrs_dp.sv @@
// ----------------------------------------------------------------------------
// itrs_dp
// Datapath: alphabet check, radix divider, digit stack and output register.
// ----------------------------------------------------------------------------
module itrs_dp #(
  parameter int unsigned MAX_RADIX = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  itrs_pkg::itrs_cmd_t           cmd_i,
  output itrs_pkg::itrs_stat_t          stat_o,
  input  logic [itrs_pkg::ValueW-1:0]   value_i,
  input  logic [itrs_pkg::SymRegW-1:0]  sym_lo_i,
  input  logic [itrs_pkg::SymRegW-1:0]  sym_hi_i,
  input  logic [itrs_pkg::RadixW-1:0]   radix_i,
  output logic                          strobe_o,
  output logic [itrs_pkg::SymW-1:0]     symbol_o,
  output logic                          last_o
);
  import itrs_pkg::*;

  localparam int unsigned DW = (MAX_RADIX > 1) ? $clog2(MAX_RADIX) : 1;
  localparam int unsigned RW = DW + 1;

  logic [SymW-1:0]  syms [MaxSymbols];
  logic             alpha_ok;

  logic [ValueW-1:0]               mag_q;
  logic [DW-1:0]                   rem_q;
  logic                            neg_q;
  logic [MaxDigits-1:0][DW-1:0]    digits_q;
  logic [DigitCntW-1:0]            nd_q;
  logic                            strobe_q;
  logic [SymW-1:0]                 symbol_q;
  logic                            last_q;

  logic [ValueW-1:0] quot_next;
  logic [RW-1:0]     rem_next;
  logic [RW-1:0]     radix_t;

  // Radix range check, and alphabet check over the symbols in use: forbidden bytes and duplicates.
  always_comb begin
    alpha_ok = (radix_i >= RadixW'(2)) && (radix_i <= RadixW'(MAX_RADIX));
    for (int i = 0; i < MaxSymbols; i++) begin
      syms[i] = sym_at(sym_lo_i, sym_hi_i, 4'(i));
    end
    for (int i = 0; i < MaxSymbols; i++) begin
      if (RadixW'(i) < radix_i) begin
        if (sym_forbidden(syms[i])) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < MaxSymbols; j++) begin
          if ((RadixW'(j) < radix_i) && (syms[j] == syms[i])) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // A quarter of a long division by the radix: eight quotient bits per cycle.
  assign radix_t = radix_i[RW-1:0];

  always_comb begin
    logic [RW-1:0]     r;
    logic [ValueW-1:0] d;
    logic              qb;
    r = {1'b0, rem_q};
    d = mag_q;
    for (int k = 0; k < BitsPerDivStep; k++) begin
      r  = {r[DW-1:0], d[ValueW-1]};
      qb = (r >= radix_t);
      if (qb) begin
        r = r - radix_t;
      end
      d = {d[ValueW-2:0], qb};
    end
    rem_next  = r;
    quot_next = d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= value_i[ValueW-1];
      mag_q <= value_i[ValueW-1] ? (~value_i + 1'b1) : value_i;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      mag_q <= quot_next;
      rem_q <= cmd_i.push ? '0 : rem_next[DW-1:0];
    end
    // The last digit pushed is the most significant and sits at index 0.
    if (cmd_i.push) begin
      digits_q <= {digits_q[MaxDigits-2:0], rem_next[DW-1:0]};
    end else if (cmd_i.emit_digit) begin
      digits_q <= {{DW{1'b0}}, digits_q[MaxDigits-1:1]};
    end
    if (cmd_i.emit_sign) begin
      symbol_q <= ChMinus;
      last_q   <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      symbol_q <= sym_at(sym_lo_i, sym_hi_i, 4'(digits_q[0]));
      last_q   <= (nd_q == DigitCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q     <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit_sign | cmd_i.emit_digit;
      if (cmd_i.load) begin
        nd_q <= '0;
      end else if (cmd_i.push) begin
        nd_q <= nd_q + 1'b1;
      end else if (cmd_i.emit_digit) begin
        nd_q <= nd_q - 1'b1;
      end
    end
  end

  assign stat_o.alpha_ok    = alpha_ok;
  assign stat_o.neg         = neg_q;
  assign stat_o.quot_zero   = (quot_next == '0);
  assign stat_o.digits_full = (nd_q == DigitCntW'(MaxDigits - 1));
  assign stat_o.last_digit  = (nd_q == DigitCntW'(1));

  assign strobe_o = strobe_q;
  assign symbol_o = symbol_q;
  assign last_o   = last_q;

endmodule

@@ sv/itrs_chk.sv @@
// ----------------------------------------------------------------------------
// itrs_chk
// Port-level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_radix_symbols_defines.svh"

module itrs_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      busy,
  input logic                      result_strobe_o,
  input logic [itrs_pkg::SymW-1:0] symbol_o,
  input logic                      last_o
);
  import itrs_pkg::*;

  // The strobe belongs to an item in progress.
  `ITRS_ASSERT(a_strobe_busy, result_strobe_o |-> busy, "result strobe while not busy")

  // An idle block gives no result in the next cycle, even if an item is taken.
  `ITRS_ASSERT(a_idle_quiet, !busy |=> !result_strobe_o, "result without work in progress")

  // The last symbol ends the item's text.
  `ITRS_ASSERT(a_last_ends, result_strobe_o && last_o |=> !result_strobe_o, "result after last symbol")

  // A minus sign always has digits after it.
  `ITRS_ASSERT(a_sign_not_last, result_strobe_o && (symbol_o == ChMinus) |-> !last_o, "minus sign flagged last")

  `ITRS_ASSERT_RST(a_reset_idle, !rst_ni |-> !result_strobe_o && !busy, "activity during reset")

endmodule

bind integer_to_radix_symbols itrs_chk u_chk (.*);
